// ===== hw/rtl/oale_pkg.sv =====
`default_nettype none

package oale_pkg;

  // List geometry
  localparam int DEPTH = 128;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // Field widths
  localparam int MODE_W  = 3;
  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 7;
  localparam int ENTRY_W = 8;

  localparam int IN_FIELDS_W  = MODE_W + POS_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STAT_W + VAL_W + FIDX_W + ENTRY_W + 2;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Cursor update selects
  localparam logic [2:0] IDX_HOLD  = 3'd0;
  localparam logic [2:0] IDX_COUNT = 3'd1;
  localparam logic [2:0] IDX_SLOT  = 3'd2;
  localparam logic [2:0] IDX_POS   = 3'd3;
  localparam logic [2:0] IDX_ZERO  = 3'd4;
  localparam logic [2:0] IDX_INC   = 3'd5;
  localparam logic [2:0] IDX_DEC   = 3'd6;

  // Memory read address selects
  localparam logic [1:0] RD_IDX  = 2'd0;
  localparam logic [1:0] RD_PREV = 2'd1;
  localparam logic [1:0] RD_NEXT = 2'd2;

  // Memory write data selects
  localparam logic WR_VAL   = 1'b0;
  localparam logic WR_RDATA = 1'b1;

  typedef struct packed {
    logic              latch;
    logic              count_clr;
    logic              count_inc;
    logic              count_dec;
    logic [2:0]        idx_sel;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              wr_en;
    logic              wr_sel;
    logic              set_status;
    logic [STAT_W-1:0] status;
    logic              cap_data;
    logic              cap_fidx;
    logic              load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_full;
    logic              cnt_zero;
    logic              pos_ok_ins;
    logic              pos_ok_del;
    logic              pos_ok_rd;
    logic              idx_at_slot;
    logic              idx_at_end;
    logic              match;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oale_dp.sv =====
`default_nettype none

module oale_dp
  import oale_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire dp_cmd_t                  cmd,
  output dp_stat_t                      stat,
  input  wire logic [MODE_W-1:0]        in_mode,
  input  wire logic [POS_W-1:0]         in_position,
  input  wire logic signed [VAL_W-1:0]  in_operand_value,
  output logic [STAT_W-1:0]             out_status,
  output logic signed [VAL_W-1:0]       out_data_out,
  output logic [FIDX_W-1:0]             out_found_index,
  output logic [ENTRY_W-1:0]            out_entry_count,
  output logic                          out_is_full,
  output logic                          out_is_empty
);

  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  logic [VAL_W-1:0]  list_mem [DEPTH];

  logic [MODE_W-1:0] mode_r;
  logic [POS_W-1:0]  pos_r;
  logic [VAL_W-1:0]  val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  rdata_r;
  logic [STAT_W-1:0] st_r;
  logic [VAL_W-1:0]  data_r;
  logic [FIDX_W-1:0] fidx_r;

  logic [STAT_W-1:0]        out_status_r;
  logic [VAL_W-1:0]         out_data_r;
  logic [FIDX_W-1:0]        out_fidx_r;
  logic [ENTRY_W-1:0]       out_count_r;
  logic                     out_full_r;
  logic                     out_empty_r;

  logic [CMP_W-1:0] pos_ext, cnt_ext, idx_ext, slot_ext, idx_p1_ext;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [VAL_W-1:0] wr_data;

  assign pos_ext    = CMP_W'(pos_r);
  assign cnt_ext    = CMP_W'(count_r);
  assign idx_ext    = CMP_W'(idx_r);
  assign slot_ext   = pos_ext - CMP_W'(1);
  assign idx_p1_ext = idx_ext + CMP_W'(1);

  always_comb begin
    stat.mode        = mode_r;
    stat.cnt_full    = (count_r == CNT_W'(DEPTH));
    stat.cnt_zero    = (count_r == '0);
    stat.pos_ok_ins  = (pos_r != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    stat.pos_ok_del  = (pos_r != '0) && (pos_ext <= cnt_ext);
    stat.pos_ok_rd   = (pos_ext < cnt_ext);
    stat.idx_at_slot = (idx_ext == slot_ext);
    stat.idx_at_end  = (idx_p1_ext >= cnt_ext);
    stat.match       = (rdata_r == val_r);
  end

  // Cursor and count
  always_comb begin
    case (cmd.idx_sel)
      IDX_COUNT: idx_nxt = count_r;
      IDX_SLOT:  idx_nxt = CNT_W'(slot_ext);
      IDX_POS:   idx_nxt = CNT_W'(pos_ext);
      IDX_ZERO:  idx_nxt = '0;
      IDX_INC:   idx_nxt = idx_r + CNT_W'(1);
      IDX_DEC:   idx_nxt = idx_r - CNT_W'(1);
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_clr) begin
      count_nxt = '0;
    end else if (cmd.count_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_PREV: rd_addr = IDX_W'(idx_r - CNT_W'(1));
      RD_NEXT: rd_addr = IDX_W'(idx_r + CNT_W'(1));
      default: rd_addr = IDX_W'(idx_r);
    endcase
  end

  assign wr_addr = IDX_W'(idx_r);
  assign wr_data = (cmd.wr_sel == WR_RDATA) ? rdata_r : val_r;

  // List storage: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= list_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_operand_value;
      st_r   <= ST_OK;
      data_r <= '0;
      fidx_r <= '0;
    end else begin
      if (cmd.set_status) begin
        st_r <= cmd.status;
      end
      if (cmd.cap_data) begin
        data_r <= rdata_r;
      end
      if (cmd.cap_fidx) begin
        fidx_r <= FIDX_W'(idx_r);
      end
    end
    if (cmd.load_out) begin
      out_status_r <= st_r;
      out_data_r   <= data_r;
      out_fidx_r   <= fidx_r;
      out_count_r  <= ENTRY_W'(count_r);
      out_full_r   <= (count_r == CNT_W'(DEPTH));
      out_empty_r  <= (count_r == '0);
    end
  end

  assign out_status      = out_status_r;
  assign out_data_out    = out_data_r;
  assign out_found_index = out_fidx_r;
  assign out_entry_count = out_count_r;
  assign out_is_full     = out_full_r;
  assign out_is_empty    = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (idx_r < CNT_W'(DEPTH)))
    else $error("list write beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      ((count_r == '0) || (count_r == $past(count_r) + CNT_W'(1)) ||
       (count_r == $past(count_r) - CNT_W'(1))))
    else $error("count moved by more than one entry");

endmodule

`default_nettype wire

// ===== hw/rtl/oale_ctrl.sv =====
`default_nettype none

module oale_ctrl
  import oale_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_INS_CHK = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_DEL_RD  = 4'd4;
  localparam logic [3:0] S_DEL_CAP = 4'd5;
  localparam logic [3:0] S_DEL_CHK = 4'd6;
  localparam logic [3:0] S_DEL_WR  = 4'd7;
  localparam logic [3:0] S_RD_RD   = 4'd8;
  localparam logic [3:0] S_RD_CAP  = 4'd9;
  localparam logic [3:0] S_SR_RD   = 4'd10;
  localparam logic [3:0] S_SR_CMP  = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       out_tvalid_r, out_tvalid_nxt;
  logic       in_fire;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        case (stat.mode)
          MODE_CLEAR: begin
            cmd.count_clr = 1'b1;
          end
          MODE_INSERT: begin
            if (stat.cnt_full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (stat.pos_ok_ins) begin
              cmd.idx_sel = IDX_COUNT;
              state_nxt   = S_INS_CHK;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end
          end
          MODE_DELETE: begin
            if (stat.cnt_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else if (stat.pos_ok_del) begin
              cmd.idx_sel = IDX_SLOT;
              state_nxt   = S_DEL_RD;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end
          end
          MODE_READ: begin
            if (stat.pos_ok_rd) begin
              cmd.idx_sel = IDX_POS;
              state_nxt   = S_RD_RD;
            end else begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_BADPOS;
            end
          end
          MODE_SEARCH: begin
            cmd.set_status = 1'b1;
            if (stat.cnt_zero) begin
              cmd.status = ST_EMPTY;
            end else begin
              cmd.status  = ST_NOTFOUND;
              cmd.idx_sel = IDX_ZERO;
              state_nxt   = S_SR_RD;
            end
          end
          default: begin
          end
        endcase
      end
      // Shift up: move entry idx-1 to idx until the slot is reached
      S_INS_CHK: begin
        if (stat.idx_at_slot) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_VAL;
          cmd.count_inc = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RDATA;
        cmd.idx_sel = IDX_DEC;
        state_nxt   = S_INS_CHK;
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.cap_data = 1'b1;
        state_nxt    = S_DEL_CHK;
      end
      // Shift down: move entry idx+1 to idx until the tail
      S_DEL_CHK: begin
        if (stat.idx_at_end) begin
          cmd.count_dec = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_nxt  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_RDATA;
        cmd.idx_sel = IDX_INC;
        state_nxt   = S_DEL_CHK;
      end
      S_RD_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_data = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SR_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_nxt  = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat.match) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
          cmd.cap_fidx   = 1'b1;
          state_nxt      = S_DONE;
        end else if (stat.idx_at_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.idx_sel = IDX_INC;
          state_nxt   = S_SR_RD;
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DECODE))
    else $error("accepted word not decoded");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_tvalid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result overwrote a pending word");

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("read and write issued together");

endmodule

`default_nettype wire

// ===== hw/rtl/ordered_array_list_engine_unit.sv =====
// Ordered list engine: keeps up to DEPTH signed 32-bit words in order, plus a count.
// Commands arrive one word at a time on the in_ stream (mode, position, value);
// each returns exactly one result word on the out_ stream (status, data, found
// index, count, full and empty flags).
// One command is worked on at a time. in_tready is high only while the engine
// is idle. A command leaves its result in an output register, so the next
// command is taken while that result still waits for out_tready.
// The next command word is taken in the same cycle that its predecessor's result
// first shows on out_tvalid. Insert and delete shift entries one at a time, each
// with a read followed by a write, and search compares one entry per read.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// the memory itself needs no clearing pass since only entries below the count
// are ever read.
// While out_tready is low the finished result is held, and a command that
// finishes behind it waits in its last state until the output frees.

`default_nettype none

module ordered_array_list_engine_unit
  import oale_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [2:0] mode, [10:3] position, [42:11] operand_value, rest zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [2:0] status, [34:3] data_out, [41:35] found_index, [49:42] entry_count,
  // [50] is_full, [51] is_empty, rest zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Unpack the command word
  logic [MODE_W-1:0]       in_mode;
  logic [POS_W-1:0]        in_position;
  logic signed [VAL_W-1:0] in_operand_value;

  assign in_mode          = in_tdata[MODE_W-1:0];
  assign in_position      = in_tdata[MODE_W +: POS_W];
  assign in_operand_value = in_tdata[MODE_W + POS_W +: VAL_W];

  // Result fields from the datapath output register
  logic [STAT_W-1:0]       res_status;
  logic signed [VAL_W-1:0] res_data;
  logic [FIDX_W-1:0]       res_fidx;
  logic [ENTRY_W-1:0]      res_count;
  logic                    res_full;
  logic                    res_empty;

  oale_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  oale_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_operand_value (in_operand_value),
    .out_status       (res_status),
    .out_data_out     (res_data),
    .out_found_index  (res_fidx),
    .out_entry_count  (res_count),
    .out_is_full      (res_full),
    .out_is_empty     (res_empty)
  );

  // Pack the result word, lowest field first, padded to whole bytes
  assign out_tdata = OUT_TDATA_W'({res_empty, res_full, res_count, res_fidx,
                                   res_data, res_status});

endmodule

`default_nettype wire

// ===== tb/ordered_array_list_engine_unit_tb.sv =====
`timescale 1ns / 100ps

module ordered_array_list_engine_unit_tb;
  import oale_pkg::*;

  // Result word as it sits in out_tdata, first field in the lowest bits
  typedef struct packed {
    logic               is_empty;
    logic               is_full;
    logic [ENTRY_W-1:0] entry_count;
    logic [FIDX_W-1:0]  found_index;
    logic [VAL_W-1:0]   data_out;
    logic [STAT_W-1:0]  status;
  } list_result_t;

  localparam int RANDOM_ITEMS = 680;
  localparam int TAIL_CYCLES  = 300;  // longest shift or scan plus margin

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // [2:0] mode, [10:3] position, [42:11] operand_value, rest zero
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // [2:0] status, [34:3] data_out, [41:35] found_index, [49:42] entry_count,
  // [50] is_full, [51] is_empty, rest zero
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Shadow copy of the list, updated as each command word is accepted
  logic [VAL_W-1:0] list_words [DEPTH];
  int               list_len;

  list_result_t pending_results [$];
  int           fail_count;
  int           sent_count;
  bit           quiet;  // when set, neither side idles

  ordered_array_list_engine_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the result of one command and update the shadow list
  function automatic list_result_t apply_command(logic [MODE_W-1:0] mode,
                                                 logic [POS_W-1:0] pos,
                                                 logic [VAL_W-1:0] val);
    list_result_t r;
    int           p;
    bit           hit;
    r   = '0;
    p   = pos;
    hit = 1'b0;
    r.status = ST_OK;
    case (mode)
      MODE_CLEAR: begin
        list_len = 0;
      end
      MODE_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p >= 1 && p <= list_len + 1) begin
          // open a gap at the slot, later entries move up
          for (int i = list_len; i > p - 1; i--) list_words[i] = list_words[i-1];
          list_words[p-1] = val;
          list_len++;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      MODE_DELETE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= 1 && p <= list_len) begin
          r.data_out = list_words[p-1];
          for (int i = p - 1; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end else begin
          r.status = ST_BADPOS;
        end
      end
      MODE_READ: begin
        // index equal to the count is rejected as well
        if (p < list_len) r.data_out = list_words[p];
        else r.status = ST_BADPOS;
      end
      MODE_SEARCH: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < list_len; i++) begin
            if (!hit && list_words[i] == val) begin
              hit           = 1'b1;
              r.status      = ST_OK;
              r.found_index = i[FIDX_W-1:0];
            end
          end
        end
      end
      default: begin
        // unused modes only report the count and flags
      end
    endcase
    r.entry_count = list_len[ENTRY_W-1:0];
    r.is_full     = (list_len == DEPTH);
    r.is_empty    = (list_len == 0);
    return r;
  endfunction

  // Offer one command word, hold it until taken, then record its result
  task automatic send_command(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                              logic [VAL_W-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, val, pos, mode};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    pending_results.push_back(apply_command(mode, pos, val));
    sent_count++;
  endtask

  // Drop valid and hold until every outstanding result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Values with a bias towards extremes and repeats, so searches see duplicates
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_insert();
    logic [POS_W-1:0] pos;
    if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 255);
    else pos = $urandom_range(1, list_len + 1);
    send_command(MODE_INSERT, pos, pick_value());
  endtask

  task automatic send_delete();
    logic [POS_W-1:0] pos;
    if ($urandom_range(0, 9) == 0 || list_len == 0) pos = $urandom_range(0, 255);
    else pos = $urandom_range(1, list_len);
    send_command(MODE_DELETE, pos, $urandom);
  endtask

  task automatic send_query();
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 7) == 0 || list_len == 0) pos = $urandom_range(0, 255);
      else pos = $urandom_range(0, list_len - 1);
      send_command(MODE_READ, pos, $urandom);
    end else begin
      // mostly look for a value that is present
      if (list_len > 0 && $urandom_range(0, 9) < 7)
        val = list_words[$urandom_range(0, list_len - 1)];
      else
        val = pick_value();
      send_command(MODE_SEARCH, $urandom_range(0, 255), val);
    end
  endtask

  task automatic test_empty_list();
    send_command(MODE_CLEAR, 8'd0, 32'd0);
    send_command(MODE_READ, 8'd0, 32'd0);
    send_command(MODE_DELETE, 8'd1, 32'd0);
    send_command(MODE_SEARCH, 8'd0, 32'd0);
    send_command(MODE_INSERT, 8'd0, 32'd5);
    send_command(MODE_INSERT, 8'd2, 32'd5);
    send_command(3'd5, 8'hff, 32'hffff_ffff);
    send_command(3'd6, 8'h00, 32'h0000_0000);
    send_command(3'd7, 8'h55, 32'h5555_5555);
  endtask

  task automatic test_edge_values();
    send_command(MODE_INSERT, 8'd1, 32'h7fff_ffff);  // into an empty list
    send_command(MODE_INSERT, 8'd1, 32'h8000_0000);
    send_command(MODE_INSERT, 8'd3, 32'h0000_0000);  // append
    send_command(MODE_INSERT, 8'd2, 32'hffff_ffff);
    send_command(MODE_INSERT, 8'd6, 32'd1);          // past the append position
    send_command(MODE_INSERT, 8'd255, 32'd1);
    send_command(MODE_READ, 8'd0, 32'd0);
    send_command(MODE_READ, 8'd3, 32'd0);
    send_command(MODE_READ, 8'd4, 32'd0);            // index equal to count
    send_command(MODE_READ, 8'd255, 32'd0);
    send_command(MODE_SEARCH, 8'd0, 32'h7fff_ffff);
    send_command(MODE_SEARCH, 8'd0, 32'd12345);      // no match
    send_command(MODE_INSERT, 8'd5, 32'h8000_0000);
    send_command(MODE_SEARCH, 8'd0, 32'h8000_0000);  // first of two matches
    send_command(MODE_DELETE, 8'd0, 32'd0);
    send_command(MODE_DELETE, 8'd6, 32'd0);
    send_command(MODE_DELETE, 8'd5, 32'd0);
    send_command(MODE_DELETE, 8'd1, 32'd0);
    send_command(MODE_CLEAR, 8'd0, 32'd0);
    send_command(MODE_READ, 8'd0, 32'd0);
  endtask

  task automatic test_full_list();
    send_command(MODE_CLEAR, 8'd0, 32'd0);
    while (list_len < DEPTH) send_command(MODE_INSERT, $urandom_range(1, list_len + 1),
                                          pick_value());
    // let the list settle before poking it while full
    wait_for_results();
    repeat ($urandom_range(1, 20)) @(negedge clk);
    send_command(MODE_INSERT, 8'd1, 32'd7);
    send_command(MODE_INSERT, 8'd129, 32'd7);
    send_command(MODE_READ, 8'd127, 32'd0);
    send_command(MODE_READ, 8'd128, 32'd0);
    send_command(MODE_SEARCH, 8'd0, list_words[DEPTH-1]);
    send_command(3'd7, 8'd0, 32'd0);
    send_command(MODE_DELETE, 8'd128, 32'd0);
    send_command(MODE_INSERT, 8'd128, pick_value());
    send_command(MODE_DELETE, 8'd1, 32'd0);
    send_command(MODE_DELETE, 8'd128, 32'd0);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int kind;
    int burst;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      kind  = $urandom_range(0, 99);
      burst = $urandom_range(3, 30);
      quiet = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < burst; k++) begin
        if (kind < 32) send_insert();
        else if (kind < 50) send_delete();
        else if (kind < 80) send_query();
        else if (kind < 86) begin
          if (k == 0) send_command(MODE_CLEAR, $urandom_range(0, 255), $urandom);
          else send_insert();
        end else begin
          // noise: any mode, any position, any value
          send_command($urandom_range(0, 7), $urandom_range(0, 255), $urandom);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_for_results();
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Check every result word against the oldest expectation
  always @(posedge clk) begin : result_check
    list_result_t want;
    list_result_t got;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = out_tdata[OUT_FIELDS_W-1:0];
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %0h", $time, got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("data_out", want.data_out, got.data_out);
        compare_field("found_index", want.found_index, got.found_index);
        compare_field("entry_count", want.entry_count, got.entry_count);
        compare_field("is_full", want.is_full, got.is_full);
        compare_field("is_empty", want.is_empty, got.is_empty);
      end
    end
  end

  // Result side: stall a random number of cycles before each word
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      repeat (stall) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : run_tests
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    quiet      = 1'b0;
    list_len   = 0;
    fail_count = 0;
    sent_count = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_random_traffic();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/oale_pkg.sv
hw/rtl/oale_dp.sv
hw/rtl/oale_ctrl.sv
hw/rtl/ordered_array_list_engine_unit.sv
tb/ordered_array_list_engine_unit_tb.sv
